// File: rtl/psou_pkg.sv
// ----------------------------------------------------------------------------
// psou_pkg
// Types, widths and helpers shared by the particle update pipeline.
// ----------------------------------------------------------------------------
package psou_pkg;

  localparam int WORD_W    = 32;  // Q16.16 data word
  localparam int GAIN_W    = 31;  // unsigned gains, limits and rate bound
  localparam int RAND_W    = 17;  // Q1.16 random, 1.0 included
  localparam int RAND_BITS = 16;
  localparam int PROD_W    = 65;  // signed product of a gain and a difference
  localparam int STEP_W    = 34;  // exact sums of a few words
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INERTIA        = 3'd0,
    CFG_COGNITIVE_GAIN = 3'd1,
    CFG_SOCIAL_GAIN    = 3'd2,
    CFG_VELOCITY_LIMIT = 3'd3
  } psou_cfg_idx_e;

  localparam logic [GAIN_W-1:0] INERTIA_RST        = 31'd58982;
  localparam logic [GAIN_W-1:0] COGNITIVE_GAIN_RST = 31'd131072;
  localparam logic [GAIN_W-1:0] SOCIAL_GAIN_RST    = 31'd131072;
  localparam logic [GAIN_W-1:0] VELOCITY_LIMIT_RST = 31'd65536;

  typedef struct packed {
    logic signed [WORD_W-1:0] position;
    logic signed [WORD_W-1:0] velocity;
    logic signed [WORD_W-1:0] personal_best;
    logic signed [WORD_W-1:0] global_best;
    logic        [RAND_W-1:0] rand_one;
    logic        [RAND_W-1:0] rand_two;
    logic                     first_step;
    logic signed [WORD_W-1:0] previous_position;
    logic signed [WORD_W-1:0] current_control;
    logic signed [WORD_W-1:0] box_min;
    logic signed [WORD_W-1:0] box_max;
    logic        [GAIN_W-1:0] rate_limit;
  } psou_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] new_position;
    logic signed [WORD_W-1:0] new_velocity;
  } psou_out_t;

  // Load enables of the three stages that a weighted term spans.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } psou_term_en_t;

  // Saturate a wide signed value to the signed word range.
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] x);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &x[PROD_W-1:WORD_W-1];
    hi_zeros = ~|x[PROD_W-1:WORD_W-1];
    if (hi_ones || hi_zeros) begin
      sat_word = x[WORD_W-1:0];
    end else if (x[PROD_W-1]) begin
      sat_word = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      sat_word = {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/psou_wterm.sv
// ----------------------------------------------------------------------------
// psou_wterm
// Three-stage weighted attraction term: gain * rand * (target - position).
// ----------------------------------------------------------------------------
module psou_wterm #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  psou_pkg::psou_term_en_t          en,
  input  logic        [psou_pkg::GAIN_W-1:0] gain,
  input  logic        [psou_pkg::RAND_W-1:0] rnd,
  input  logic signed [psou_pkg::WORD_W-1:0] target,
  input  logic signed [psou_pkg::WORD_W-1:0] position,
  output logic signed [psou_pkg::WORD_W-1:0] term
);
  import psou_pkg::*;

  localparam int G_W  = GAIN_W + RAND_W;
  localparam int GS_W = G_W - RAND_BITS;

  logic        [G_W-1:0]    scaled;
  logic signed [WORD_W:0]   diff;
  logic        [GS_W-1:0]   gsh;
  logic        [GAIN_W-1:0] gsat;
  logic signed [PROD_W-1:0] prod;

  // The scaled gain only exceeds 31 bits for a random above 1.0.
  assign gsh  = scaled[G_W-1:RAND_BITS];
  assign gsat = (|gsh[GS_W-1:GAIN_W]) ? {GAIN_W{1'b1}} : gsh[GAIN_W-1:0];

  always_ff @(posedge clk) begin
    if (en.s1) begin
      scaled <= G_W'(gain) * G_W'(rnd);
      diff   <= (WORD_W+1)'(target) - (WORD_W+1)'(position);
    end
    if (en.s2) begin
      prod <= PROD_W'($signed({1'b0, gsat})) * PROD_W'(diff);
    end
    if (en.s3) begin
      term <= sat_word(prod >>> FRAC_BITS);
    end
  end

endmodule

// File: rtl/pso_particle_update_rate_limited_core.sv
// ----------------------------------------------------------------------------
// pso_particle_update_rate_limited_core
// Particle swarm element update with velocity saturation and rate-limited,
// box-clamped position.
// ----------------------------------------------------------------------------
// Usage: each input word on in_data carries one element of one particle with
// its bests, two randoms and the channel's bounds. For every word accepted
// (in_valid and in_ready high) exactly one word appears on out_data with the
// saturated new velocity and the constrained new position, in order.
// The gains and the velocity limit are written through cfg_write, cfg_index
// and cfg_data; the user must do so only while no word is in flight, which
// the block does not enforce. Writes to unused indexes are ignored. Accepted
// words pass through seven register stages (two multiplier stages, saturation,
// velocity sum, position sum, step clamp, box clamp in the output register)
// before out_valid rises. Throughput is one word per cycle while out_ready is
// high; when it is low the stages fill in turn: in_ready stays high while any
// stage is empty and drops only once all seven hold a word. Synchronous reset
// empties the pipeline and restores the default gains.
// ----------------------------------------------------------------------------
module pso_particle_update_rate_limited_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  psou_pkg::psou_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output psou_pkg::psou_out_t                 out_data,
  input  logic                                cfg_write,
  input  logic [psou_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psou_pkg::GAIN_W-1:0]         cfg_data
);
  import psou_pkg::*;

  localparam int NS = 7;

  typedef struct packed {
    logic signed [WORD_W-1:0] x;
    logic signed [STEP_W-1:0] step_hi;
    logic signed [STEP_W-1:0] step_lo;
    logic signed [WORD_W-1:0] bmin;
    logic signed [WORD_W-1:0] bmax;
  } ctx_t;

  logic [GAIN_W-1:0] inertia;
  logic [GAIN_W-1:0] cognitive_gain;
  logic [GAIN_W-1:0] social_gain;
  logic [GAIN_W-1:0] velocity_limit;

  logic [NS-1:0] vld;
  logic [NS-1:0] vld_next;
  logic [NS:0]   rdy;
  logic [NS-1:0] en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      inertia        <= INERTIA_RST;
      cognitive_gain <= COGNITIVE_GAIN_RST;
      social_gain    <= SOCIAL_GAIN_RST;
      velocity_limit <= VELOCITY_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_INERTIA:        inertia        <= cfg_data;
        CFG_COGNITIVE_GAIN: cognitive_gain <= cfg_data;
        CFG_SOCIAL_GAIN:    social_gain    <= cfg_data;
        CFG_VELOCITY_LIMIT: velocity_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its successor is moving on.
  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign en       = rdy[NS-1:0];
  assign in_ready = rdy[0];

  always_comb begin
    vld_next = vld;
    if (en[0]) begin
      vld_next[0] = in_valid;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        vld_next[k] = vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  // Weighted attraction terms, stages one to three.
  psou_term_en_t                term_en;
  logic signed [WORD_W-1:0]     cog_term;
  logic signed [WORD_W-1:0]     soc_term;

  assign term_en = '{s1: en[0], s2: en[1], s3: en[2]};

  psou_wterm #(.FRAC_BITS(FRAC_BITS)) u_cog (
    .clk      (clk),
    .en       (term_en),
    .gain     (cognitive_gain),
    .rnd      (in_data.rand_one),
    .target   (in_data.personal_best),
    .position (in_data.position),
    .term     (cog_term)
  );

  psou_wterm #(.FRAC_BITS(FRAC_BITS)) u_soc (
    .clk      (clk),
    .en       (term_en),
    .gain     (social_gain),
    .rnd      (in_data.rand_two),
    .target   (in_data.global_best),
    .position (in_data.position),
    .term     (soc_term)
  );

  // Stage one: inertia product and raw step bounds.
  logic signed [PROD_W-1:0] s1_iprod;
  logic signed [WORD_W-1:0] s1_x;
  logic signed [STEP_W-1:0] s1_hi_raw;
  logic signed [STEP_W-1:0] s1_lo_raw;
  logic signed [STEP_W-1:0] s1_prev_hi;
  logic signed [STEP_W-1:0] s1_prev_lo;
  logic                     s1_first;
  logic signed [WORD_W-1:0] s1_bmin;
  logic signed [WORD_W-1:0] s1_bmax;
  logic signed [STEP_W-1:0] rate_ext;

  assign rate_ext = STEP_W'($signed({1'b0, in_data.rate_limit}));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_iprod   <= PROD_W'($signed({1'b0, inertia})) * PROD_W'(in_data.velocity);
      s1_x       <= in_data.position;
      s1_hi_raw  <= STEP_W'(in_data.current_control) + rate_ext;
      s1_lo_raw  <= STEP_W'(in_data.current_control) - rate_ext;
      s1_prev_hi <= STEP_W'(in_data.previous_position) + rate_ext;
      s1_prev_lo <= STEP_W'(in_data.previous_position) - rate_ext;
      s1_first   <= in_data.first_step;
      s1_bmin    <= in_data.box_min;
      s1_bmax    <= in_data.box_max;
    end
  end

  // Stage two: inertia term saturation, step bounds for this horizon step.
  // Both cases reduce to one clamp: the first step to the box intersected
  // with the control window, later steps to the previous position plus or
  // minus the rate limit.
  logic signed [WORD_W-1:0] s2_iterm;
  ctx_t                     s2_ctx;
  ctx_t                     s2_ctx_next;

  always_comb begin
    s2_ctx_next.x    = s1_x;
    s2_ctx_next.bmin = s1_bmin;
    s2_ctx_next.bmax = s1_bmax;
    if (s1_first) begin
      s2_ctx_next.step_hi = (s1_hi_raw > STEP_W'(s1_bmax)) ? STEP_W'(s1_bmax) : s1_hi_raw;
      s2_ctx_next.step_lo = (s1_lo_raw < STEP_W'(s1_bmin)) ? STEP_W'(s1_bmin) : s1_lo_raw;
    end else begin
      s2_ctx_next.step_hi = s1_prev_hi;
      s2_ctx_next.step_lo = s1_prev_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_iterm <= sat_word(s1_iprod >>> FRAC_BITS);
      s2_ctx   <= s2_ctx_next;
    end
  end

  // Stage three: terms settle alongside the context.
  logic signed [WORD_W-1:0] s3_iterm;
  ctx_t                     s3_ctx;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_iterm <= s2_iterm;
      s3_ctx   <= s2_ctx;
    end
  end

  // Stage four: velocity sum and magnitude limit.
  logic signed [STEP_W-1:0] v_sum;
  logic signed [STEP_W-1:0] vmax_ext;
  logic signed [STEP_W-1:0] v_lim;
  logic signed [WORD_W-1:0] s4_nv;
  ctx_t                     s4_ctx;

  assign v_sum    = STEP_W'(s3_iterm) + STEP_W'(cog_term) + STEP_W'(soc_term);
  assign vmax_ext = STEP_W'($signed({1'b0, velocity_limit}));

  always_comb begin
    if (v_sum > vmax_ext) begin
      v_lim = vmax_ext;
    end else if (v_sum < -vmax_ext) begin
      v_lim = -vmax_ext;
    end else begin
      v_lim = v_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_nv  <= v_lim[WORD_W-1:0];
      s4_ctx <= s3_ctx;
    end
  end

  // Stage five: moved position.
  logic signed [STEP_W-1:0] s5_nx;
  logic signed [WORD_W-1:0] s5_nv;
  ctx_t                     s5_ctx;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_nx  <= STEP_W'(s4_ctx.x) + STEP_W'(s4_nv);
      s5_nv  <= s4_nv;
      s5_ctx <= s4_ctx;
    end
  end

  // Stage six: step clamp, upper bound tested first.
  logic signed [STEP_W-1:0] step_nx;
  logic signed [STEP_W-1:0] s6_nx;
  logic signed [WORD_W-1:0] s6_nv;
  logic signed [WORD_W-1:0] s6_bmin;
  logic signed [WORD_W-1:0] s6_bmax;

  always_comb begin
    if (s5_nx > s5_ctx.step_hi) begin
      step_nx = s5_ctx.step_hi;
    end else if (s5_nx < s5_ctx.step_lo) begin
      step_nx = s5_ctx.step_lo;
    end else begin
      step_nx = s5_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_nx   <= step_nx;
      s6_nv   <= s5_nv;
      s6_bmin <= s5_ctx.bmin;
      s6_bmax <= s5_ctx.bmax;
    end
  end

  // Stage seven: box clamp into the output register.
  logic signed [STEP_W-1:0] box_nx;

  always_comb begin
    if (s6_nx > STEP_W'(s6_bmax)) begin
      box_nx = STEP_W'(s6_bmax);
    end else if (s6_nx < STEP_W'(s6_bmin)) begin
      box_nx = STEP_W'(s6_bmin);
    end else begin
      box_nx = s6_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      out_data.new_position <= box_nx[WORD_W-1:0];
      out_data.new_velocity <= s6_nv;
    end
  end

  assign out_valid = vld[NS-1];

`ifndef ASSERT_OFF
  // The output stage is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pipeline not empty after reset");

  // An empty output stage never blocks the input.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !vld[NS-1] |-> in_ready)
    else $error("input stalled with an empty output stage");

  // Words in flight grow by one on an accept without a delivery.
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !(out_valid && out_ready))
      |=> $countones(vld) == $past($countones(vld)) + 1)
    else $error("word lost or invented on input");

  // Words in flight drop by one on a delivery without an accept.
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (!(in_valid && in_ready) && out_valid && out_ready)
      |=> $countones(vld) == $past($countones(vld)) - 1)
    else $error("word lost or repeated on output");
`endif

endmodule
